// ===== src/dam_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dam_pkg: shared types and constants
// Codes, widths and state types for the decimal accumulator machine.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int MEM_WORDS_DEF = 10000;
  localparam int WORD_BITS_DEF = 32;
  localparam int ADDR_BITS     = 14;
  localparam int IO_BITS       = 32;
  localparam int FUNC_BITS     = 2;
  localparam int STATUS_BITS   = 3;
  localparam int OP_BITS       = 4;
  localparam int INSTR_RADIX   = 10000;
  localparam int OP_COUNT      = 13;

  localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_STEP  = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_HALTED      = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_BAD_OPCODE  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_DIV_ZERO    = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_RANGE       = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_WAIT_INPUT  = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_NOT_STARTED = 3'd6;

  localparam logic [OP_BITS-1:0] OP_ADD   = 4'd1;
  localparam logic [OP_BITS-1:0] OP_SUB   = 4'd2;
  localparam logic [OP_BITS-1:0] OP_MUL   = 4'd3;
  localparam logic [OP_BITS-1:0] OP_DIV   = 4'd4;
  localparam logic [OP_BITS-1:0] OP_LOAD  = 4'd5;
  localparam logic [OP_BITS-1:0] OP_STORE = 4'd6;
  localparam logic [OP_BITS-1:0] OP_READ  = 4'd7;
  localparam logic [OP_BITS-1:0] OP_WRITE = 4'd8;
  localparam logic [OP_BITS-1:0] OP_B     = 4'd9;
  localparam logic [OP_BITS-1:0] OP_BM    = 4'd10;
  localparam logic [OP_BITS-1:0] OP_BZ    = 4'd11;
  localparam logic [OP_BITS-1:0] OP_BP    = 4'd12;
  localparam logic [OP_BITS-1:0] OP_HALT  = 4'd13;

  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_GO,
    RUN_HALT
  } run_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_START,
    S_START_DATA,
    S_EXEC,
    S_FETCH,
    S_DECODE,
    S_OPER,
    S_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic div;
  } md_ctl_t;

endpackage
`default_nettype wire

// ===== src/dam_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dam_if: request and response channels
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface dam_req_if;
  logic                              valid;
  logic                              ready;
  logic [dam_pkg::FUNC_BITS-1:0]     func;
  logic [dam_pkg::ADDR_BITS-1:0]     load_address;
  logic signed [dam_pkg::IO_BITS-1:0] load_word;
  logic                              input_valid;
  logic signed [dam_pkg::IO_BITS-1:0] input_value;

  modport source(output valid, func, load_address, load_word, input_valid, input_value,
                 input ready);
  modport sink(input valid, func, load_address, load_word, input_valid, input_value,
               output ready);
endinterface

interface dam_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [dam_pkg::STATUS_BITS-1:0]    status;
  logic                               write_valid;
  logic signed [dam_pkg::IO_BITS-1:0] write_value;
  logic [dam_pkg::ADDR_BITS-1:0]      program_counter;
  logic signed [dam_pkg::IO_BITS-1:0] accumulator_out;

  modport source(output valid, status, write_valid, write_value, program_counter,
                 accumulator_out, input ready);
  modport sink(input valid, status, write_valid, write_value, program_counter,
               accumulator_out, output ready);
endinterface
`default_nettype wire

// ===== src/dam_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dam_mem: main memory
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module dam_mem #(
  parameter int DEPTH = dam_pkg::MEM_WORDS_DEF,
  parameter int WIDTH = dam_pkg::WORD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/dam_muldiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dam_muldiv: iterative multiply / divide unit
// Shift-add multiply (low word) and restoring signed divide, one bit a cycle
// through a single shared adder.
// ----------------------------------------------------------------------------
module dam_muldiv #(
  parameter int WORD_BITS = dam_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dam_pkg::md_ctl_t     ctl,
  input  wire logic [WORD_BITS-1:0] a,
  input  wire logic [WORD_BITS-1:0] b,
  output logic                      done,
  output logic [WORD_BITS-1:0]      result
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic                 busy;
  logic                 is_div;
  logic                 neg;
  logic [CW-1:0]        cnt;
  logic [WORD_BITS-1:0] x;
  logic [WORD_BITS-1:0] y;
  logic [WORD_BITS-1:0] prod;
  logic [WORD_BITS:0]   rem;
  logic [WORD_BITS:0]   sh;
  logic [WORD_BITS:0]   op_a;
  logic [WORD_BITS:0]   op_b;
  logic [WORD_BITS:0]   sum;
  logic                 cin;

  always_comb begin
    sh = {rem[WORD_BITS-1:0], x[WORD_BITS-1]};
    if (is_div) begin
      op_a = sh;
      op_b = ~{1'b0, y};
      cin  = 1'b1;
    end else begin
      op_a = {1'b0, prod};
      op_b = {1'b0, x};
      cin  = 1'b0;
    end
    sum = op_a + op_b + (WORD_BITS + 1)'(cin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy   <= 1'b1;
        is_div <= ctl.div;
        cnt    <= CW'(WORD_BITS);
        rem    <= '0;
        prod   <= '0;
        neg    <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
        if (ctl.div) begin
          x <= a[WORD_BITS-1] ? (~a + 1'b1) : a;
          y <= b[WORD_BITS-1] ? (~b + 1'b1) : b;
        end else begin
          x <= a;
          y <= b;
        end
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
          if (is_div) begin
            if (!sum[WORD_BITS]) begin
              rem <= sum;
              x   <= {x[WORD_BITS-2:0], 1'b1};
            end else begin
              rem <= sh;
              x   <= {x[WORD_BITS-2:0], 1'b0};
            end
          end else begin
            if (y[0]) begin
              prod <= sum[WORD_BITS-1:0];
            end
            x <= x << 1;
            y <= y >> 1;
          end
        end else begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= is_div ? (neg ? (~x + 1'b1) : x) : prod;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/decimal_accumulator_machine_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_accumulator_machine_top: decimal accumulator computer
// Sequencer around main memory and an iterative multiply/divide unit.
//
// Usage:
//   req carries one action per beat: func 0 writes load_word to memory at
//   load_address, func 1 starts the program at the address held in word 0,
//   func 2 executes the instruction at pc (a read instruction takes
//   input_value when input_valid is set). Each request beat gives exactly
//   one rsp beat with status, write_valid/write_value, pc and accumulator.
//   An unknown func is answered too; mul and div take longest, their time
//   set by the bit-serial unit. One request is in flight at a time;
//   req.ready is high only between requests.
//   The response sits in an output register; a new request is taken while
//   it waits, and the next response holds until rsp.ready frees the slot.
//   Reset clears pc, accumulator and run state (not started) and drops any
//   pending response; memory contents are undefined until loaded.
// ----------------------------------------------------------------------------
module decimal_accumulator_machine_top #(
  parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF,
  parameter int WORD_BITS = dam_pkg::WORD_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  dam_req_if.sink   req,
  dam_rsp_if.source rsp
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int AB = dam_pkg::ADDR_BITS;

  dam_pkg::state_t state, state_next;
  dam_pkg::run_t   run, run_next;

  logic [AB-1:0]                    pc, pc_next;
  logic [WORD_BITS-1:0]             acc, acc_next;
  logic [dam_pkg::STATUS_BITS-1:0]  status, status_next;
  logic                             wvalid, wvalid_next;
  logic [dam_pkg::IO_BITS-1:0]      wvalue, wvalue_next;
  logic [dam_pkg::OP_BITS-1:0]      op, op_next;
  logic [AB-1:0]                    addr, addr_next;

  logic [dam_pkg::FUNC_BITS-1:0]    func_r;
  logic [AB-1:0]                    laddr_r;
  logic [dam_pkg::IO_BITS-1:0]      lword_r;
  logic                             ivalid_r;
  logic [dam_pkg::IO_BITS-1:0]      ivalue_r;

  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic [WORD_BITS-1:0]             mem_wdata;
  logic [AW-1:0]                    mem_raddr;
  logic [WORD_BITS-1:0]             rdata;

  dam_pkg::md_ctl_t                 md_ctl;
  logic                             md_done;
  logic [WORD_BITS-1:0]             md_result;

  logic [63:0]                      rd_zext;
  logic [63:0]                      rd_sext;
  logic [63:0]                      acc_sext;
  logic [63:0]                      lword_sext;
  logic [63:0]                      ivalue_sext;
  logic                             acc_neg;
  logic                             inmem;
  logic                             accept;
  logic                             out_free;
  logic [AB-1:0]                    pc_inc;

  assign accept      = req.valid && req.ready;
  assign req.ready   = (state == dam_pkg::S_IDLE);
  assign out_free    = !rsp.valid || rsp.ready;
  assign rd_zext     = 64'(rdata);
  assign rd_sext     = 64'($signed(rdata));
  assign acc_sext    = 64'($signed(acc));
  assign lword_sext  = 64'($signed(lword_r));
  assign ivalue_sext = 64'($signed(ivalue_r));
  assign acc_neg     = acc[WORD_BITS-1];
  assign inmem       = 32'(addr) < 32'(MEM_WORDS);
  assign pc_inc      = pc + 1'b1;

  dam_mem #(
    .DEPTH(MEM_WORDS),
    .WIDTH(WORD_BITS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  dam_muldiv #(
    .WORD_BITS(WORD_BITS)
  ) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .ctl   (md_ctl),
    .a     (acc),
    .b     (rdata),
    .done  (md_done),
    .result(md_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dam_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    run_next    = run;
    pc_next     = pc;
    acc_next    = acc;
    status_next = status;
    wvalid_next = wvalid;
    wvalue_next = wvalue;
    op_next     = op;
    addr_next   = addr;
    mem_we      = 1'b0;
    mem_waddr   = addr[AW-1:0];
    mem_wdata   = acc;
    mem_raddr   = pc[AW-1:0];
    md_ctl      = '0;

    case (state)
      dam_pkg::S_IDLE: begin
        if (accept) begin
          status_next = dam_pkg::ST_OK;
          wvalid_next = 1'b0;
          wvalue_next = '0;
          case (req.func)
            dam_pkg::FUNC_LOAD:  state_next = dam_pkg::S_LOAD;
            dam_pkg::FUNC_START: state_next = dam_pkg::S_START;
            dam_pkg::FUNC_STEP:  state_next = dam_pkg::S_EXEC;
            default:             state_next = dam_pkg::S_FINISH;
          endcase
        end
      end
      dam_pkg::S_LOAD: begin
        if (32'(laddr_r) < 32'(MEM_WORDS)) begin
          mem_we    = 1'b1;
          mem_waddr = laddr_r[AW-1:0];
          mem_wdata = lword_sext[WORD_BITS-1:0];
        end else begin
          status_next = dam_pkg::ST_RANGE;
        end
        state_next = dam_pkg::S_FINISH;
      end
      dam_pkg::S_START: begin
        mem_raddr  = '0;
        state_next = dam_pkg::S_START_DATA;
      end
      dam_pkg::S_START_DATA: begin
        run_next = dam_pkg::RUN_GO;
        if (rdata[WORD_BITS-1] || rd_zext >= 64'(MEM_WORDS)) begin
          pc_next     = AB'(MEM_WORDS);
          status_next = dam_pkg::ST_RANGE;
        end else begin
          pc_next = rd_zext[AB-1:0];
        end
        state_next = dam_pkg::S_FINISH;
      end
      dam_pkg::S_EXEC: begin
        if (run == dam_pkg::RUN_IDLE) begin
          status_next = dam_pkg::ST_NOT_STARTED;
          state_next  = dam_pkg::S_FINISH;
        end else if (run == dam_pkg::RUN_HALT) begin
          status_next = dam_pkg::ST_HALTED;
          state_next  = dam_pkg::S_FINISH;
        end else if (32'(pc) >= 32'(MEM_WORDS)) begin
          status_next = dam_pkg::ST_RANGE;
          state_next  = dam_pkg::S_FINISH;
        end else begin
          state_next = dam_pkg::S_FETCH;
        end
      end
      dam_pkg::S_FETCH: begin
        op_next = '0;
        if (!rdata[WORD_BITS-1] &&
            rd_zext < 64'(dam_pkg::INSTR_RADIX * (dam_pkg::OP_COUNT + 1))) begin
          for (int k = 1; k <= dam_pkg::OP_COUNT; k++) begin
            if (rd_zext >= 64'(k * dam_pkg::INSTR_RADIX)) begin
              op_next = dam_pkg::OP_BITS'(k);
            end
          end
        end
        addr_next  = AB'(rd_zext - 64'(op_next) * 64'(dam_pkg::INSTR_RADIX));
        state_next = dam_pkg::S_DECODE;
      end
      dam_pkg::S_DECODE: begin
        mem_raddr  = addr[AW-1:0];
        state_next = dam_pkg::S_FINISH;
        if (op == '0 || op > dam_pkg::OP_HALT) begin
          status_next = dam_pkg::ST_BAD_OPCODE;
        end else if (op <= dam_pkg::OP_WRITE && !inmem) begin
          status_next = dam_pkg::ST_RANGE;
        end else begin
          case (op)
            dam_pkg::OP_STORE: begin
              mem_we  = 1'b1;
              pc_next = pc_inc;
            end
            dam_pkg::OP_READ: begin
              if (ivalid_r) begin
                mem_we    = 1'b1;
                mem_wdata = ivalue_sext[WORD_BITS-1:0];
                pc_next   = pc_inc;
              end else begin
                status_next = dam_pkg::ST_WAIT_INPUT;
              end
            end
            dam_pkg::OP_B:  pc_next = addr;
            dam_pkg::OP_BM: pc_next = acc_neg ? addr : pc_inc;
            dam_pkg::OP_BZ: pc_next = (acc == '0) ? addr : pc_inc;
            dam_pkg::OP_BP: pc_next = (!acc_neg && acc != '0) ? addr : pc_inc;
            dam_pkg::OP_HALT: begin
              run_next    = dam_pkg::RUN_HALT;
              status_next = dam_pkg::ST_HALTED;
            end
            default: state_next = dam_pkg::S_OPER;
          endcase
        end
      end
      dam_pkg::S_OPER: begin
        state_next = dam_pkg::S_FINISH;
        case (op)
          dam_pkg::OP_ADD: begin
            acc_next = acc + rdata;
            pc_next  = pc_inc;
          end
          dam_pkg::OP_SUB: begin
            acc_next = acc - rdata;
            pc_next  = pc_inc;
          end
          dam_pkg::OP_LOAD: begin
            acc_next = rdata;
            pc_next  = pc_inc;
          end
          dam_pkg::OP_WRITE: begin
            wvalid_next = 1'b1;
            wvalue_next = rd_sext[dam_pkg::IO_BITS-1:0];
            pc_next     = pc_inc;
          end
          dam_pkg::OP_MUL: begin
            md_ctl.start = 1'b1;
            state_next   = dam_pkg::S_WAIT;
          end
          dam_pkg::OP_DIV: begin
            if (rdata == '0) begin
              status_next = dam_pkg::ST_DIV_ZERO;
            end else begin
              md_ctl.start = 1'b1;
              md_ctl.div   = 1'b1;
              state_next   = dam_pkg::S_WAIT;
            end
          end
          default: status_next = dam_pkg::ST_BAD_OPCODE;
        endcase
      end
      dam_pkg::S_WAIT: begin
        if (md_done) begin
          acc_next   = md_result;
          pc_next    = pc_inc;
          state_next = dam_pkg::S_FINISH;
        end
      end
      dam_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = dam_pkg::S_IDLE;
        end
      end
      default: state_next = dam_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= dam_pkg::RUN_IDLE;
      pc  <= '0;
      acc <= '0;
    end else begin
      run <= run_next;
      pc  <= pc_next;
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    wvalid <= wvalid_next;
    wvalue <= wvalue_next;
    op     <= op_next;
    addr   <= addr_next;
    if (accept) begin
      func_r   <= req.func;
      laddr_r  <= req.load_address;
      lword_r  <= req.load_word;
      ivalid_r <= req.input_valid;
      ivalue_r <= req.input_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == dam_pkg::S_FINISH && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dam_pkg::S_FINISH && out_free) begin
      rsp.status          <= (func_r == dam_pkg::FUNC_LOAD || func_r == dam_pkg::FUNC_START ||
                              func_r == dam_pkg::FUNC_STEP) ? status : dam_pkg::ST_OK;
      rsp.write_valid     <= wvalid;
      rsp.write_value     <= wvalue;
      rsp.program_counter <= pc;
      rsp.accumulator_out <= acc_sext[dam_pkg::IO_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== src/dam_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dam_checker: port-level checks
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module dam_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [2:0]  status,
  input wire logic        write_valid,
  input wire logic [31:0] write_value
);

  // hold response while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // busy after a request beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= dam_pkg::ST_NOT_STARTED)
    else $error("status code out of range");

  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && write_valid |-> status == dam_pkg::ST_OK)
    else $error("write beat with error status");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !write_valid |-> write_value == 32'd0)
    else $error("write value set without write");

endmodule

bind decimal_accumulator_machine_top dam_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .write_valid(rsp.write_valid),
  .write_value(rsp.write_value)
);
`default_nettype wire

// ===== sim/tb_decimal_accumulator_machine_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_accumulator_machine_top: self-checking bench for the machine
// Builds short programs one beat at a time, predicts every response with
// an in-bench copy of memory, pc, accumulator and run state, and compares
// each response beat field by field under random source and sink pressure.
// ----------------------------------------------------------------------------
module tb_decimal_accumulator_machine_top;
  import dam_pkg::*;

  localparam int MEM_WORDS    = MEM_WORDS_DEF;
  localparam int RANDOM_BEATS = 800;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [FUNC_BITS-1:0] func;
    logic [ADDR_BITS-1:0] load_address;
    logic [IO_BITS-1:0]   load_word;
    logic                 input_valid;
    logic [IO_BITS-1:0]   input_value;
  } action_t;

  typedef struct {
    logic [STATUS_BITS-1:0] status;
    logic                   write_valid;
    logic [IO_BITS-1:0]     write_value;
    logic [ADDR_BITS-1:0]   program_counter;
    logic [IO_BITS-1:0]     accumulator_out;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dam_req_if req_if ();
  dam_rsp_if rsp_if ();

  decimal_accumulator_machine_top i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #4 clk = ~clk;

  // machine copy
  logic [IO_BITS-1:0] mem_copy [MEM_WORDS];
  bit                 mem_written [MEM_WORDS];
  int unsigned        pc_copy;
  logic [IO_BITS-1:0] acc_copy;
  run_t               run_copy;

  action_t  action_queue [$];
  outcome_t outcome_queue [$];

  int  errors;
  int  beats_in;
  int  beats_out;
  int  writes_seen;
  int  cycles;
  int  status_seen [8];
  int  hold_left;
  bit  hold_done;
  bit  req_taken;
  int  total_beats;

  function automatic outcome_t step_machine(action_t a);
    outcome_t           o;
    logic [IO_BITS-1:0] w, m, ma, mb, q;
    int unsigned        op, addr, next_pc;
    o = '{ST_OK, 1'b0, '0, '0, '0};
    if (a.func == FUNC_LOAD) begin
      if (a.load_address < MEM_WORDS) begin
        mem_copy[a.load_address] = a.load_word;
        mem_written[a.load_address] = 1'b1;
      end else begin
        o.status = ST_RANGE;
      end
    end else if (a.func == FUNC_START) begin
      w = mem_copy[0];
      run_copy = RUN_GO;
      if (w[31] || w >= MEM_WORDS) begin
        pc_copy = MEM_WORDS;
        o.status = ST_RANGE;
      end else begin
        pc_copy = w;
      end
    end else if (a.func == FUNC_STEP) begin
      if (run_copy == RUN_IDLE) begin
        o.status = ST_NOT_STARTED;
      end else if (run_copy == RUN_HALT) begin
        o.status = ST_HALTED;
      end else if (pc_copy >= MEM_WORDS) begin
        o.status = ST_RANGE;
      end else begin
        w = mem_copy[pc_copy];
        op = w[31] ? 0 : w / INSTR_RADIX;
        addr = w[31] ? 0 : w % INSTR_RADIX;
        m = mem_copy[addr];
        next_pc = pc_copy + 1;
        if (op == 0 || op > OP_COUNT) begin
          o.status = ST_BAD_OPCODE;
        end else begin
          case (op[OP_BITS-1:0])
            OP_ADD: acc_copy = acc_copy + m;
            OP_SUB: acc_copy = acc_copy - m;
            OP_MUL: acc_copy = acc_copy * m;
            OP_DIV: begin
              if (m == 0) begin
                o.status = ST_DIV_ZERO;
              end else begin
                ma = acc_copy[31] ? -acc_copy : acc_copy;
                mb = m[31] ? -m : m;
                q = ma / mb;
                acc_copy = (acc_copy[31] ^ m[31]) ? -q : q;
              end
            end
            OP_LOAD: acc_copy = m;
            OP_STORE: begin
              mem_copy[addr] = acc_copy;
              mem_written[addr] = 1'b1;
            end
            OP_READ: begin
              if (a.input_valid) begin
                mem_copy[addr] = a.input_value;
                mem_written[addr] = 1'b1;
              end else begin
                o.status = ST_WAIT_INPUT;
              end
            end
            OP_WRITE: begin
              o.write_valid = 1'b1;
              o.write_value = m;
            end
            OP_B: next_pc = addr;
            OP_BM: if (acc_copy[31]) next_pc = addr;
            OP_BZ: if (acc_copy == 0) next_pc = addr;
            OP_BP: if (!acc_copy[31] && acc_copy != 0) next_pc = addr;
            default: begin
              o.status = ST_HALTED;
              run_copy = RUN_HALT;
              next_pc = pc_copy;
            end
          endcase
          if (o.status == ST_OK || o.status == ST_HALTED) pc_copy = next_pc;
        end
      end
    end
    o.program_counter = pc_copy;
    o.accumulator_out = acc_copy;
    return o;
  endfunction

  function automatic logic [IO_BITS-1:0] rand_data();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return $urandom;
      default: return $urandom_range(200) - 100;
    endcase
  endfunction

  function automatic int unsigned rand_target();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(40);
    if (r < 95) return $urandom_range(MEM_WORDS - 1, MEM_WORDS - 10);
    return $urandom_range(MEM_WORDS - 1);
  endfunction

  function automatic logic [IO_BITS-1:0] rand_instr();
    int r;
    r = $urandom_range(99);
    if (r < 90) return $urandom_range(OP_COUNT, 1) * INSTR_RADIX + rand_target();
    if (r < 93) return rand_target();
    if (r < 97) return $urandom_range(214, OP_COUNT + 1) * INSTR_RADIX + rand_target();
    return $urandom | 32'h8000_0000;
  endfunction

  task automatic put_action(logic [FUNC_BITS-1:0] f, logic [ADDR_BITS-1:0] la,
                            logic [IO_BITS-1:0] lw, logic iv, logic [IO_BITS-1:0] v);
    action_t a;
    a = '{f, la, lw, iv, v};
    outcome_queue.push_back(step_machine(a));
    action_queue.push_back(a);
  endtask

  // keep every word that a step may touch written
  task automatic safe_step(logic iv, logic [IO_BITS-1:0] v);
    logic [IO_BITS-1:0] w;
    if (run_copy == RUN_GO && pc_copy < MEM_WORDS) begin
      if (!mem_written[pc_copy]) put_action(FUNC_LOAD, pc_copy, rand_instr(), 0, 0);
      w = mem_copy[pc_copy];
      if (w[31] && !mem_written[0]) put_action(FUNC_LOAD, 0, rand_data(), 0, 0);
      if (!w[31] && !mem_written[w % INSTR_RADIX])
        put_action(FUNC_LOAD, w % INSTR_RADIX, rand_data(), 0, 0);
    end
    put_action(FUNC_STEP, $urandom, $urandom, iv, v);
  endtask

  task automatic run_instr(logic [IO_BITS-1:0] w, logic iv, logic [IO_BITS-1:0] v);
    if (run_copy == RUN_GO && pc_copy < MEM_WORDS) put_action(FUNC_LOAD, pc_copy, w, 0, 0);
    safe_step(iv, v);
  endtask

  task automatic safe_start();
    if (!mem_written[0]) put_action(FUNC_LOAD, 0, $urandom_range(40, 1), 0, 0);
    put_action(FUNC_START, $urandom, $urandom, 0, 0);
  endtask

  task automatic build_stimulus();
    int r;
    // directed: errors before start, range cases, each opcode, corner arithmetic
    put_action(FUNC_LOAD, 16383, 32'hffff_ffff, 1, 32'hffff_ffff);
    put_action(FUNC_STEP, 0, 0, 0, 0);
    put_action(3, 16383, 32'h5a5a_5a5a, 1, 32'ha5a5_a5a5);
    put_action(FUNC_LOAD, 0, 32'h8000_0000, 0, 0);
    put_action(FUNC_START, 0, 0, 0, 0);
    put_action(FUNC_STEP, 0, 0, 0, 0);
    put_action(FUNC_LOAD, 0, 99999, 0, 0);
    put_action(FUNC_START, 0, 0, 0, 0);
    put_action(FUNC_LOAD, 1, 32'h7fff_ffff, 0, 0);
    put_action(FUNC_LOAD, 2, 32'h8000_0000, 0, 0);
    put_action(FUNC_LOAD, 3, 32'hffff_ffff, 0, 0);
    put_action(FUNC_LOAD, 4, 0, 0, 0);
    put_action(FUNC_LOAD, MEM_WORDS - 1, 32'h0000_0007, 0, 0);
    put_action(FUNC_LOAD, 0, 10, 0, 0);
    put_action(FUNC_START, 0, 0, 0, 0);
    run_instr(OP_LOAD * INSTR_RADIX + 2, 0, 0);
    run_instr(OP_DIV * INSTR_RADIX + 3, 0, 0);
    run_instr(OP_DIV * INSTR_RADIX + 4, 0, 0);
    run_instr(OP_MUL * INSTR_RADIX + 3, 0, 0);
    run_instr(OP_ADD * INSTR_RADIX + 1, 0, 0);
    run_instr(OP_SUB * INSTR_RADIX + 1, 0, 0);
    run_instr(OP_WRITE * INSTR_RADIX + 1, 0, 0);
    run_instr(OP_STORE * INSTR_RADIX + 5, 0, 0);
    run_instr(OP_READ * INSTR_RADIX + 6, 0, 0);
    safe_step(1, 32'h8000_0001);
    run_instr(OP_BM * INSTR_RADIX + 20, 0, 0);
    run_instr(OP_BZ * INSTR_RADIX + 30, 0, 0);
    run_instr(OP_BP * INSTR_RADIX + 30, 0, 0);
    run_instr(OP_B * INSTR_RADIX + MEM_WORDS - 1, 0, 0);
    run_instr(OP_ADD * INSTR_RADIX + 4, 0, 0);
    safe_step(0, 0);
    put_action(FUNC_START, 0, 0, 0, 0);
    run_instr(14 * INSTR_RADIX + 3, 0, 0);
    run_instr(32'hffff_fff0, 0, 0);
    run_instr(3, 0, 0);
    run_instr(OP_HALT * INSTR_RADIX, 0, 0);
    safe_step(0, 0);
    // random programs built as they run
    while (action_queue.size() < RANDOM_BEATS + 40) begin
      r = $urandom_range(99);
      if (r < 6) begin
        if ($urandom_range(9) == 0)
          put_action(FUNC_LOAD, 0, ($urandom_range(1)) ? rand_data() : rand_target(), 0, 0);
        safe_start();
      end else if (r < 14) begin
        case ($urandom_range(3))
          0: put_action(FUNC_LOAD, $urandom_range(16383, MEM_WORDS), $urandom, 0, 0);
          1: put_action(FUNC_LOAD, rand_target(), rand_instr(), 0, 0);
          default: put_action(FUNC_LOAD, rand_target(), rand_data(), $urandom, $urandom);
        endcase
      end else if (r < 17) begin
        put_action(3, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 30) begin
        safe_step($urandom_range(3) != 0, rand_data());
      end else begin
        run_instr(rand_instr(), $urandom_range(3) != 0, rand_data());
      end
    end
  endtask

  function automatic int phase_now();
    return (beats_in * 4) / (total_beats + 1);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_taken) void'(action_queue.pop_front());
      if (req_if.valid && !req_taken) begin
      end else if (action_queue.size() > 0 &&
                   !(phase_now() == 1 && $urandom_range(99) < 49) &&
                   !(phase_now() == 3 && $urandom_range(99) < 21)) begin
        req_if.valid        <= 1'b1;
        req_if.func         <= action_queue[0].func;
        req_if.load_address <= action_queue[0].load_address;
        req_if.load_word    <= action_queue[0].load_word;
        req_if.input_valid  <= action_queue[0].input_valid;
        req_if.input_value  <= action_queue[0].input_value;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // sink ready, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (!hold_done && beats_in >= 150) begin
      hold_left    <= 400;
      hold_done    <= 1'b1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !((phase_now() == 2 && $urandom_range(99) < 49) ||
                        (phase_now() == 3 && $urandom_range(99) < 21));
    end
  end

  task automatic report_mismatch(string field, longint expv, longint gotv);
    errors++;
    $display("[%0t] response %0d: %s expected %0d, got %0d", $realtime, beats_out, field,
             expv, gotv);
  endtask

  // monitor
  always @(posedge clk) begin
    outcome_t e;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
    req_taken = !rst && req_if.valid && req_if.ready;
    if (req_taken) beats_in++;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (outcome_queue.size() == 0) begin
        errors++;
        $display("[%0t] response with nothing pending", $realtime);
      end else begin
        e = outcome_queue.pop_front();
        status_seen[rsp_if.status]++;
        if (rsp_if.write_valid) writes_seen++;
        if (rsp_if.status !== e.status)
          report_mismatch("status", e.status, rsp_if.status);
        if (rsp_if.write_valid !== e.write_valid)
          report_mismatch("write_valid", e.write_valid, rsp_if.write_valid);
        if (rsp_if.write_value !== e.write_value)
          report_mismatch("write_value", $signed(e.write_value), rsp_if.write_value);
        if (rsp_if.program_counter !== e.program_counter)
          report_mismatch("program_counter", e.program_counter, rsp_if.program_counter);
        if (rsp_if.accumulator_out !== e.accumulator_out)
          report_mismatch("accumulator_out", $signed(e.accumulator_out),
                          rsp_if.accumulator_out);
      end
      beats_out++;
    end
  end

  initial begin
    req_if.valid        = 1'b0;
    req_if.func         = '0;
    req_if.load_address = '0;
    req_if.load_word    = '0;
    req_if.input_valid  = 1'b0;
    req_if.input_value  = '0;
    rsp_if.ready        = 1'b0;
    pc_copy  = 0;
    acc_copy = '0;
    run_copy = RUN_IDLE;
    build_stimulus();
    total_beats = action_queue.size();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (action_queue.size() > 0 || outcome_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d request beats, %0d responses, %0d with a write, in %0d cycles",
             total_beats, beats_out, writes_seen, cycles);
    $display("Status mix ok/halt/badop/div0/range/wait/idle: %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== decimal_accumulator_machine_top.f =====
src/dam_pkg.sv
src/dam_if.sv
src/dam_mem.sv
src/dam_muldiv.sv
src/decimal_accumulator_machine_top.sv
src/dam_checker.sv
sim/tb_decimal_accumulator_machine_top.sv
